// ===== design/m4vt_pkg.sv =====
// Package for the 4x4 matrix-vector transform: word types, kind codes and number formats.
`timescale 1ns / 1ps

package m4vt_pkg;

    localparam int DIM       = 4;
    localparam int FRAC_BITS = 16;

    localparam int VEC_LEN   = 4;
    localparam int N_WORDS   = 16;
    localparam int IDX_W     = 4;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int SUM_W     = PROD_W + 2;

    localparam logic [IDX_W:0]  N_ENTRIES = (IDX_W + 1)'(DIM * DIM);
    localparam logic [DATA_W-1:0] FIX_ONE = DATA_W'(1 << FRAC_BITS);

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_IDENT = 2'd1;
    localparam logic [1:0] KIND_XFORM = 2'd2;

    typedef struct packed {
        logic [1:0]               kind;
        logic [IDX_W-1:0]         entry_index;
        logic signed [DATA_W-1:0] entry_value;
        logic signed [DATA_W-1:0] vec_x;
        logic signed [DATA_W-1:0] vec_y;
        logic signed [DATA_W-1:0] vec_z;
        logic signed [DATA_W-1:0] vec_w;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_W-1:0] res_x;
        logic signed [DATA_W-1:0] res_y;
        logic signed [DATA_W-1:0] res_z;
        logic signed [DATA_W-1:0] res_w;
        logic                     overflow;
    } t_out_word;

endpackage

// ===== design/m4vt_if.sv =====
// Valid/ready channel interfaces for the input and result words.
`timescale 1ns / 1ps

interface m4vt_in_if;
    logic               valid;
    logic               ready;
    m4vt_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface m4vt_out_if;
    logic                valid;
    logic                ready;
    m4vt_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/matrix4_vector_transform.sv =====
// Top level: 4x4 Q16.16 matrix store and three-stage matrix-times-vector pipeline.
//
// Usage:
//   i_in carries one word per handshake (valid & ready). kind 0 writes one
//   column-major matrix entry, kind 1 loads the identity, kind 2 sends a
//   vector. Only kind 2 produces a word on o_out: the four rounded,
//   saturated components and an overflow flag.
//   Pipeline: input register, product register (16 parallel 32x32
//   multipliers), result register. An accepted vector passes through all
//   three to o_out; one word per cycle is sustained while o_out does not stall.
//   Matrix writes take effect as the word leaves the input register, so
//   each vector sees exactly the writes sent ahead of it.
//   Reset clears the matrix to zero and empties the pipeline.
//   When o_out stalls, the stages fill up; i_in.ready drops only when the
//   input, product and result registers all hold a vector.
`timescale 1ns / 1ps

module matrix4_vector_transform (
    input  logic i_clk,
    input  logic i_rst_n,
    m4vt_in_if.sink    i_in,
    m4vt_out_if.source o_out
);
    import m4vt_pkg::*;

    localparam logic signed [SUM_W-1:0] RES_MAX = {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] RES_MIN = {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] RND     = SUM_W'(1) << (FRAC_BITS - 1);

    logic signed [DATA_W-1:0] r_mat [N_WORDS];

    logic     r_v1;
    t_in_word r_s1;
    logic     r_v2;
    logic signed [PROD_W-1:0] r_prod [DIM][DIM];
    logic      r_ov;
    t_out_word r_out;

    logic s3_free, s2_free, s2_go, s1_go, in_acc, s1_xform;
    logic signed [DATA_W-1:0] vec [VEC_LEN];
    logic signed [PROD_W-1:0] n_prod [DIM][DIM];
    logic signed [DATA_W-1:0] res [VEC_LEN];
    logic n_overflow;

    assign s1_xform = (r_s1.kind == KIND_XFORM);
    assign s3_free  = !r_ov || o_out.ready;
    assign s2_free  = !r_v2 || s3_free;
    assign s2_go    = r_v2 && s3_free;
    assign s1_go    = r_v1 && (!s1_xform || s2_free);
    assign i_in.ready = !r_v1 || s1_go;
    assign in_acc   = i_in.valid && i_in.ready;

    assign vec[0] = r_s1.vec_x;
    assign vec[1] = r_s1.vec_y;
    assign vec[2] = r_s1.vec_z;
    assign vec[3] = r_s1.vec_w;

    // stage 1: one product per matrix entry
    always_comb begin
        for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
                n_prod[r][c] = PROD_W'(r_mat[c * DIM + r]) * PROD_W'(vec[c]);
            end
        end
    end

    // stage 2: row sums, round half up, saturate
    always_comb begin
        logic signed [SUM_W-1:0] acc;
        logic signed [SUM_W-1:0] sh;
        n_overflow = 1'b0;
        for (int r = 0; r < VEC_LEN; r++) begin
            res[r] = '0;
        end
        for (int r = 0; r < DIM; r++) begin
            acc = RND;
            for (int c = 0; c < DIM; c++) begin
                acc = acc + SUM_W'(r_prod[r][c]);
            end
            sh = acc >>> FRAC_BITS;
            if (sh > RES_MAX) begin
                res[r]     = RES_MAX[DATA_W-1:0];
                n_overflow = 1'b1;
            end else if (sh < RES_MIN) begin
                res[r]     = RES_MIN[DATA_W-1:0];
                n_overflow = 1'b1;
            end else begin
                res[r] = sh[DATA_W-1:0];
            end
        end
    end

    // control and matrix store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
            for (int i = 0; i < N_WORDS; i++) begin
                r_mat[i] <= '0;
            end
        end else begin
            if (in_acc) begin
                r_v1 <= 1'b1;
            end else if (s1_go) begin
                r_v1 <= 1'b0;
            end

            if (s1_go && s1_xform) begin
                r_v2 <= 1'b1;
            end else if (s2_go) begin
                r_v2 <= 1'b0;
            end

            if (s2_go) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end

            if (s1_go) begin
                case (r_s1.kind)
                    KIND_WRITE: begin
                        if ({1'b0, r_s1.entry_index} < N_ENTRIES) begin
                            r_mat[r_s1.entry_index] <= r_s1.entry_value;
                        end
                    end
                    KIND_IDENT: begin
                        // diagonal entries sit every DIM + 1 words
                        for (int i = 0; i < N_WORDS; i++) begin
                            r_mat[i] <= ((i % (DIM + 1) == 0) && (i < DIM * DIM)) ?
                                        FIX_ONE : '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= i_in.data;
        end
        if (s1_go && s1_xform) begin
            r_prod <= n_prod;
        end
        if (s2_go) begin
            r_out.res_x    <= res[0];
            r_out.res_y    <= res[1];
            r_out.res_z    <= res[2];
            r_out.res_w    <= res[3];
            r_out.overflow <= n_overflow;
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    a_ovf_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.overflow |->
            (o_out.data.res_x == RES_MAX[DATA_W-1:0]) ||
            (o_out.data.res_x == RES_MIN[DATA_W-1:0]) ||
            (o_out.data.res_y == RES_MAX[DATA_W-1:0]) ||
            (o_out.data.res_y == RES_MIN[DATA_W-1:0]) ||
            (o_out.data.res_z == RES_MAX[DATA_W-1:0]) ||
            (o_out.data.res_z == RES_MIN[DATA_W-1:0]) ||
            (o_out.data.res_w == RES_MAX[DATA_W-1:0]) ||
            (o_out.data.res_w == RES_MIN[DATA_W-1:0]))
        else $error("overflow flag without a clamped component");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> r_v1 && s1_xform && r_v2 && o_out.valid && !o_out.ready)
        else $error("input stalled while the pipeline has room");

    a_ident: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && (r_s1.kind == KIND_IDENT) |=> r_mat[0] == FIX_ONE)
        else $error("identity load did not set the first diagonal entry");

    a_stage2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !s3_free |=> r_v2)
        else $error("product stage dropped a word under stall");

endmodule

// ===== test/tb_matrix4_vector_transform.sv =====
// Testbench for matrix4_vector_transform: directed table plus random matrix/vector words.
`timescale 1ns / 1ps

module tb_matrix4_vector_transform;
    import m4vt_pkg::*;

    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam int CLK_PERIOD  = 20;
    localparam int HOLD_CYCLES = 200;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [67:0] SAT_HI = 68'sh7fff_ffff;
    localparam logic signed [67:0] SAT_LO = -68'sh8000_0000;
    localparam logic signed [67:0] ROUND_HALF = 68'sd1 <<< (FRAC_BITS - 1);

    typedef struct {
        t_in_word  w;
        bit        typed;
        t_out_word res;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    m4vt_in_if  in_ch ();
    m4vt_out_if out_ch ();

    matrix4_vector_transform DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    logic signed [31:0] mat_shadow [16] = '{default: '0};
    t_out_word pending_xforms [$];
    t_stim_row stim_rows [$];
    int  err_count     = 0;
    int  n_items       = 0;
    int  cycle_count   = 0;
    int  rx_stall_left = 0;
    bit  rx_hold_req   = 1'b0;
    bit  tx_idle_en    = 1'b1;
    bit  rx_idle_en    = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_matrix4_vector_transform: FAIL");
        $finish;
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_count < 50) begin
            $display("mismatch %s: got %h want %h at %0t", field, got, want, $time);
        end
        err_count++;
    endtask

    // Shadow of the matrix store; returns 1 when the word yields a result.
    function automatic bit matrix_apply(input t_in_word w, output t_out_word r);
        logic signed [63:0] m;
        logic signed [63:0] v;
        logic signed [67:0] acc;
        logic signed [31:0] vec [4];
        logic signed [31:0] res [4];
        bit sat;
        r = '0;
        case (w.kind)
            KIND_WRITE: begin
                if (w.entry_index < DIM * DIM) mat_shadow[w.entry_index] = w.entry_value;
                return 1'b0;
            end
            KIND_IDENT: begin
                foreach (mat_shadow[i]) mat_shadow[i] = '0;
                for (int i = 0; i < DIM; i++) mat_shadow[(i * DIM + i) & 15] = FIX_ONE;
                return 1'b0;
            end
            KIND_XFORM: begin
                vec = '{w.vec_x, w.vec_y, w.vec_z, w.vec_w};
                sat = 1'b0;
                for (int row = 0; row < 4; row++) begin
                    res[row] = '0;
                    if (row < DIM) begin
                        acc = '0;
                        for (int c = 0; c < DIM; c++) begin
                            m = mat_shadow[(c * DIM + row) & 15];
                            v = vec[c];
                            acc = acc + m * v;
                        end
                        acc = (acc + ROUND_HALF) >>> FRAC_BITS;
                        if (acc > SAT_HI) begin
                            res[row] = Q_MAX;
                            sat = 1'b1;
                        end else if (acc < SAT_LO) begin
                            res[row] = Q_MIN;
                            sat = 1'b1;
                        end else begin
                            res[row] = acc[31:0];
                        end
                    end
                end
                r.res_x = res[0];
                r.res_y = res[1];
                r.res_z = res[2];
                r.res_w = res[3];
                r.overflow = sat;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Unused fields carry random junk.
    function automatic t_in_word mk_word(input logic [1:0] k);
        t_in_word w;
        w.kind        = k;
        w.entry_index = 4'($urandom);
        w.entry_value = $urandom;
        w.vec_x       = $urandom;
        w.vec_y       = $urandom;
        w.vec_z       = $urandom;
        w.vec_w       = $urandom;
        return w;
    endfunction

    function automatic t_in_word mk_write(input logic [3:0] idx, input logic signed [31:0] val);
        t_in_word w;
        w = mk_word(KIND_WRITE);
        w.entry_index = idx;
        w.entry_value = val;
        return w;
    endfunction

    function automatic t_in_word mk_xform(input logic signed [31:0] x, input logic signed [31:0] y,
                                          input logic signed [31:0] z,
                                          input logic signed [31:0] wc);
        t_in_word w;
        w = mk_word(KIND_XFORM);
        w.vec_x = x;
        w.vec_y = y;
        w.vec_z = z;
        w.vec_w = wc;
        return w;
    endfunction

    function automatic t_out_word mk_res(input logic signed [31:0] x, input logic signed [31:0] y,
                                         input logic signed [31:0] z,
                                         input logic signed [31:0] wc, input logic ovf);
        t_out_word r;
        r.res_x    = x;
        r.res_y    = y;
        r.res_z    = z;
        r.res_w    = wc;
        r.overflow = ovf;
        return r;
    endfunction

    function automatic logic signed [31:0] rand_fix();
        case ($urandom_range(0, 11))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return FIX_ONE;
            4:       return -FIX_ONE;
            5, 6:    return $urandom;
            default: return int'($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
        endcase
    endfunction

    task automatic send_word(input t_in_word w, input bit typed = 1'b0,
                             input t_out_word typed_res = '0);
        t_out_word r;
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        if (matrix_apply(w, r)) pending_xforms.push_back(typed ? typed_res : r);
        if (w.kind != KIND_NONE) n_items++;
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_xforms.size() != 0);
    endtask

    task automatic send_xforms(input int n);
        repeat (n) send_word(mk_xform(rand_fix(), rand_fix(), rand_fix(), rand_fix()));
    endtask

    // Result side: random stalls plus one long hold on request.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_stall_left > 0) begin
                rx_stall_left--;
                out_ch.ready <= 1'b0;
            end else if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                rx_stall_left = HOLD_CYCLES - 1;
                out_ch.ready <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
                rx_stall_left = $urandom_range(0, 10);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_word want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_xforms.size() == 0) begin
                report_mismatch("unexpected word res_x", out_ch.data.res_x, '0);
            end else begin
                want = pending_xforms.pop_front();
                if (out_ch.data.res_x !== want.res_x)
                    report_mismatch("res_x", out_ch.data.res_x, want.res_x);
                if (out_ch.data.res_y !== want.res_y)
                    report_mismatch("res_y", out_ch.data.res_y, want.res_y);
                if (out_ch.data.res_z !== want.res_z)
                    report_mismatch("res_z", out_ch.data.res_z, want.res_z);
                if (out_ch.data.res_w !== want.res_w)
                    report_mismatch("res_w", out_ch.data.res_w, want.res_w);
                if (out_ch.data.overflow !== want.overflow)
                    report_mismatch("overflow", 32'(out_ch.data.overflow), 32'(want.overflow));
            end
        end
    end

    initial begin
        bit hold_done;
        bit drain_done;
        bit idle_on;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        i_rst_n     <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // matrix is zero after reset
        stim_rows.push_back('{mk_xform(Q_MAX, Q_MIN, Q_MAX, Q_MIN), 1'b1,
                              mk_res(0, 0, 0, 0, 1'b0)});
        stim_rows.push_back('{mk_word(KIND_NONE), 1'b0, '0});
        stim_rows.push_back('{mk_word(KIND_IDENT), 1'b0, '0});
        stim_rows.push_back('{mk_xform(Q_MAX, Q_MIN, 1, -1), 1'b1,
                              mk_res(Q_MAX, Q_MIN, 1, -1, 1'b0)});
        stim_rows.push_back('{mk_write(4'd0, Q_MAX), 1'b0, '0});
        stim_rows.push_back('{mk_write(4'd5, Q_MIN), 1'b0, '0});
        stim_rows.push_back('{mk_xform(Q_MAX, Q_MIN, 2, -2), 1'b1,
                              mk_res(Q_MAX, Q_MAX, 2, -2, 1'b1)});
        stim_rows.push_back('{mk_xform(Q_MIN, Q_MAX, 0, 0), 1'b1,
                              mk_res(Q_MIN, Q_MIN, 0, 0, 1'b1)});
        // rounding: half goes up, minus half goes to zero
        stim_rows.push_back('{mk_word(KIND_IDENT), 1'b0, '0});
        stim_rows.push_back('{mk_write(4'd0, 1), 1'b0, '0});
        stim_rows.push_back('{mk_xform(32'sh8000, 0, 0, 0), 1'b1, mk_res(1, 0, 0, 0, 1'b0)});
        stim_rows.push_back('{mk_xform(-32'sh8000, 0, 0, 0), 1'b1, mk_res(0, 0, 0, 0, 1'b0)});
        stim_rows.push_back('{mk_xform(32'sh7fff, 0, 0, 0), 1'b1, mk_res(0, 0, 0, 0, 1'b0)});
        stim_rows.push_back('{mk_xform(-32'sh8001, 0, 0, 0), 1'b1, mk_res(-1, 0, 0, 0, 1'b0)});
        // off-diagonal and diagonal entries, column-major order
        stim_rows.push_back('{mk_write(4'd4, 32'sh2_0000), 1'b0, '0});
        stim_rows.push_back('{mk_write(4'd14, -32'sh3_0000), 1'b0, '0});
        stim_rows.push_back('{mk_write(4'd10, 32'shffff_8000), 1'b0, '0});
        stim_rows.push_back('{mk_xform(rand_fix(), rand_fix(), rand_fix(), rand_fix()), 1'b0, '0});
        stim_rows.push_back('{mk_write(4'd3, Q_MAX), 1'b0, '0});
        stim_rows.push_back('{mk_write(4'd15, Q_MIN), 1'b0, '0});
        stim_rows.push_back('{mk_xform(32'sh1_8000, -32'sh2_4000, 32'sh7fff_0000, 32'sh10),
                              1'b0, '0});
        stim_rows.push_back('{mk_word(KIND_NONE), 1'b0, '0});
        stim_rows.push_back('{mk_xform(rand_fix(), rand_fix(), rand_fix(), rand_fix()), 1'b0, '0});
        stim_rows.push_back('{mk_word(KIND_IDENT), 1'b0, '0});
        stim_rows.push_back('{mk_xform(0, 0, 0, 0), 1'b1, mk_res(0, 0, 0, 0, 1'b0)});

        foreach (stim_rows[i]) send_word(stim_rows[i].w, stim_rows[i].typed, stim_rows[i].res);

        while (n_items < 650) begin
            if (n_items >= 550) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end else if ($urandom_range(0, 15) == 0) begin
                idle_on = ($urandom_range(0, 2) != 0);
                tx_idle_en = idle_on;
                rx_idle_en = idle_on;
            end
            if (!hold_done && n_items >= 200) begin
                hold_done   = 1'b1;
                idle_on     = tx_idle_en;
                tx_idle_en  = 1'b0;
                rx_hold_req = 1'b1;
                send_xforms(20);
                tx_idle_en  = idle_on;
            end
            if (!drain_done && n_items >= 380) begin
                drain_done = 1'b1;
                wait_for_results();
            end
            case ($urandom_range(0, 9))
                0: send_word(mk_word(KIND_NONE));
                1: begin
                    send_word(mk_word(KIND_IDENT));
                    send_xforms($urandom_range(1, 6));
                end
                2, 3, 4, 5: begin
                    repeat ($urandom_range(1, 16))
                        send_word(mk_write(4'($urandom_range(0, 15)), rand_fix()));
                    send_xforms($urandom_range(1, 6));
                end
                default: send_xforms($urandom_range(1, 8));
            endcase
        end

        wait_for_results();
        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_matrix4_vector_transform: PASS");
        end else begin
            $display("tb_matrix4_vector_transform: FAIL");
        end
        $finish;
    end

endmodule
